// ===== rtl/core/sfrlw_pkg.sv =====
// Shared types and constants for the serial frame receiver with link watch.
`default_nettype none

package sfrlw_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned HUNT_W     = 5;
   localparam int unsigned POS_W      = 3;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned BODY_DATA  = 6;   // stick and button bytes
   localparam int unsigned BODY_STORE = 7;   // data bytes plus sum byte

   // csr indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAILER = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAIL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NEUTRAL = 3'd4;

   // csr reset values
   localparam logic [BYTE_W-1:0] HEADER_RST  = 8'hEB;
   localparam logic [BYTE_W-1:0] TRAILER_RST = 8'hAF;
   localparam logic [HUNT_W-1:0] HUNT_RST    = 5'd15;
   localparam logic [BYTE_W-1:0] FAIL_RST    = 8'd3;
   localparam logic [BYTE_W-1:0] NEUTRAL_RST = 8'd50;

   localparam logic [BYTE_W-1:0] FAIL_CNT_MAX = 8'hFF;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_GOOD    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] header_byte;
      logic [BYTE_W-1:0] trailer_byte;
      logic [HUNT_W-1:0] hunt_limit;
      logic [BYTE_W-1:0] fail_limit;
      logic [BYTE_W-1:0] neutral_level;
   } cfg_type;

   // last member lands in the lowest bits
   typedef struct packed {
      logic [BYTE_W-1:0]   sum_byte;
      logic [BYTE_W-1:0]   buttons_high;
      logic [BYTE_W-1:0]   buttons_low;
      logic [BYTE_W-1:0]   right_y;
      logic [BYTE_W-1:0]   right_x;
      logic [BYTE_W-1:0]   left_y;
      logic [BYTE_W-1:0]   left_x;
      logic                link_lost;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   localparam int unsigned RSP_W   = $bits(rsp_type);
   localparam int unsigned TDATA_W = ((RSP_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== rtl/core/sfrlw_csr.sv =====
// Configuration registers written through the csr write port.
`default_nettype none

module sfrlw_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [sfrlw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sfrlw_pkg::BYTE_W-1:0]     csr_wdata,
   output sfrlw_pkg::cfg_type                    cfg
);

   sfrlw_pkg::cfg_type cfg_ff;
   sfrlw_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            sfrlw_pkg::CSR_HEADER:  cfg_in.header_byte   = csr_wdata;
            sfrlw_pkg::CSR_TRAILER: cfg_in.trailer_byte  = csr_wdata;
            sfrlw_pkg::CSR_HUNT:    cfg_in.hunt_limit    = csr_wdata[sfrlw_pkg::HUNT_W-1:0];
            sfrlw_pkg::CSR_FAIL:    cfg_in.fail_limit    = csr_wdata;
            sfrlw_pkg::CSR_NEUTRAL: cfg_in.neutral_level = csr_wdata;
            default:                cfg_in = cfg_ff;   // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte   <= sfrlw_pkg::HEADER_RST;
         cfg_ff.trailer_byte  <= sfrlw_pkg::TRAILER_RST;
         cfg_ff.hunt_limit    <= sfrlw_pkg::HUNT_RST;
         cfg_ff.fail_limit    <= sfrlw_pkg::FAIL_RST;
         cfg_ff.neutral_level <= sfrlw_pkg::NEUTRAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sfrlw_parser.sv =====
// Header hunt, body collection, frame check and failure counter.
`default_nettype none

module sfrlw_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sfrlw_pkg::cfg_type            cfg,
   input  wire logic                          beat_acc,
   input  wire logic [sfrlw_pkg::BYTE_W-1:0]  rx_byte,
   output logic                               res_valid,
   output sfrlw_pkg::rsp_type                 res
);

   logic                             in_body_ff, in_body_in;
   logic [sfrlw_pkg::HUNT_W-1:0]     hunt_count_ff, hunt_count_in;
   logic [sfrlw_pkg::POS_W-1:0]      byte_position_ff, byte_position_in;
   logic [sfrlw_pkg::BYTE_W-1:0]     running_sum_ff, running_sum_in;
   logic [sfrlw_pkg::BYTE_W-1:0]     failure_count_ff, failure_count_in;
   logic [sfrlw_pkg::BYTE_W-1:0]     frame_bytes_ff [sfrlw_pkg::BODY_STORE];

   logic                             store_en;
   logic                             fail_evt;
   logic [sfrlw_pkg::STATUS_W-1:0]   fail_status;
   logic [sfrlw_pkg::BYTE_W-1:0]     fail_count_next;
   logic                             lost;

   // saturating bump, used only when a failure is reported
   assign fail_count_next = (failure_count_ff == sfrlw_pkg::FAIL_CNT_MAX) ?
                            failure_count_ff : failure_count_ff + 8'd1;
   assign lost = fail_count_next > cfg.fail_limit;

   always_comb begin
      in_body_in       = in_body_ff;
      hunt_count_in    = hunt_count_ff;
      byte_position_in = byte_position_ff;
      running_sum_in   = running_sum_ff;
      failure_count_in = failure_count_ff;
      store_en         = 1'b0;
      fail_evt         = 1'b0;
      fail_status      = sfrlw_pkg::STATUS_BAD;
      res_valid        = 1'b0;
      res              = '0;

      if (beat_acc) begin
         if (!in_body_ff) begin
            if (rx_byte == cfg.header_byte) begin
               in_body_in       = 1'b1;
               hunt_count_in    = '0;
               byte_position_in = '0;
               running_sum_in   = '0;
            end else if (hunt_count_ff >= cfg.hunt_limit) begin
               hunt_count_in = '0;
               fail_evt      = 1'b1;
               fail_status   = sfrlw_pkg::STATUS_TIMEOUT;
            end else begin
               hunt_count_in = hunt_count_ff + 5'd1;
            end
         end else if (byte_position_ff < sfrlw_pkg::POS_W'(sfrlw_pkg::BODY_STORE)) begin
            store_en = 1'b1;
            if (byte_position_ff < sfrlw_pkg::POS_W'(sfrlw_pkg::BODY_DATA)) begin
               running_sum_in = running_sum_ff + rx_byte;
            end
            byte_position_in = byte_position_ff + 3'd1;
         end else begin
            // end marker byte closes the frame
            in_body_in       = 1'b0;
            byte_position_in = '0;
            hunt_count_in    = '0;
            if (running_sum_ff == frame_bytes_ff[6] && rx_byte == cfg.trailer_byte) begin
               res_valid        = 1'b1;
               res.status       = sfrlw_pkg::STATUS_GOOD;
               res.link_lost    = 1'b0;
               res.left_x       = frame_bytes_ff[0];
               res.left_y       = frame_bytes_ff[1];
               res.right_x      = frame_bytes_ff[2];
               res.right_y      = frame_bytes_ff[3];
               res.buttons_low  = frame_bytes_ff[4];
               res.buttons_high = frame_bytes_ff[5];
               res.sum_byte     = frame_bytes_ff[6];
               failure_count_in = '0;
            end else begin
               fail_evt = 1'b1;
            end
         end

         if (fail_evt) begin
            res_valid        = 1'b1;
            res.status       = fail_status;
            failure_count_in = fail_count_next;
            if (lost) begin
               res.link_lost = 1'b1;
               res.left_x    = cfg.neutral_level;
               res.left_y    = cfg.neutral_level;
               res.right_x   = cfg.neutral_level;
               res.right_y   = cfg.neutral_level;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff       <= 1'b0;
         hunt_count_ff    <= '0;
         byte_position_ff <= '0;
         running_sum_ff   <= '0;
         failure_count_ff <= '0;
      end else begin
         in_body_ff       <= in_body_in;
         hunt_count_ff    <= hunt_count_in;
         byte_position_ff <= byte_position_in;
         running_sum_ff   <= running_sum_in;
         failure_count_ff <= failure_count_in;
      end
   end

   // body bytes, no reset: each is written before the frame end reads it
   always_ff @(posedge clock) begin
      if (store_en) begin
         frame_bytes_ff[byte_position_ff] <= rx_byte;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sfrlw_rsp_buf.sv =====
// Output register with a skid stage on the result stream.
`default_nettype none

module sfrlw_rsp_buf (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sfrlw_pkg::rsp_type push_data,
   output logic                    can_take,
   output logic                    out_valid,
   output sfrlw_pkg::rsp_type      out_data,
   input  wire logic               out_ready
);

   logic               out_valid_ff, out_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   sfrlw_pkg::rsp_type out_data_ff, out_data_in;
   sfrlw_pkg::rsp_type skid_data_ff, skid_data_in;
   logic               pop;

   assign pop = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no push can arrive while the skid is full
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign can_take  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/serial_frame_receiver_link_watch_unit.sv =====
// Top level: serial frame receiver with header hunt, checksum check and link watch.
// A result beat is on rsp_tvalid in the cycle after the req beat that closes a frame
//   or times out the header hunt, when the output register is free or drains as that
//   beat is taken; other bytes give no result beat.
// Throughput: one req beat per cycle while req_tready is high; the parser state update
//   uses only compares and an 8-bit add between the accepted byte and the result register.
// req_tready drops only while both the output register and the skid stage hold beats.
// Reset (synchronous): hunting, counters cleared, csr registers at their defaults.
`default_nettype none

module serial_frame_receiver_link_watch_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input byte stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [sfrlw_pkg::BYTE_W-1:0]        req_tdata,   // [7:0] rx_byte
   // result stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [1:0] status, [2] link_lost, [10:3] left_x, [18:11] left_y, [26:19] right_x,
   // [34:27] right_y, [42:35] buttons_low, [50:43] buttons_high, [58:51] sum_byte,
   // [63:59] zero
   output logic [sfrlw_pkg::TDATA_W-1:0]            rsp_tdata,
   // configuration writes
   input  wire logic                                csr_wr_en,
   input  wire logic [sfrlw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sfrlw_pkg::BYTE_W-1:0]        csr_wdata
);

   sfrlw_pkg::cfg_type cfg;
   sfrlw_pkg::rsp_type res;
   sfrlw_pkg::rsp_type out_data;
   logic               res_valid;
   logic               can_take;
   logic               beat_acc;

   assign req_tready = can_take;
   assign beat_acc   = req_tvalid && can_take;

   sfrlw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // all per-byte work happens here, straight from the accepted beat
   sfrlw_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .beat_acc  (beat_acc),
      .rx_byte   (req_tdata),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register plus skid: input keeps flowing while one result waits
   sfrlw_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .can_take  (can_take),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {{(sfrlw_pkg::TDATA_W - sfrlw_pkg::RSP_W){1'b0}}, out_data};

endmodule

`default_nettype wire
